// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sine unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SMU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, off while reset is high
`define SMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// state the cycle after reset
`define SMU_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("%m: reset check failed");

`endif

// ----- rtl/smu_pkg.sv -----
// ----------------------------------------------------------------------------
// smu_pkg
// Fixed formats and Q.40 constants of the sine unit.
// ----------------------------------------------------------------------------
package smu_pkg;

   localparam int ANGLE_W = 32;
   localparam int SINE_W  = 32;

   // polynomial datapath word, Q.40 in 42 signed bits
   localparam int TW      = 42;
   localparam int QF      = 40;
   localparam int PP_LO_W = 20;   // low slice of the multiplier operand
   localparam int LO_SHIFT = 24;  // Q.64 -> Q.40

   typedef logic signed [TW-1:0] coef_type;

   localparam logic [31:0]        TWO_OVER_PI_Q32 = 32'hA2F9836E;
   localparam coef_type           PIO2_HI_Q40     = 42'sh1921FB54440;
   localparam logic signed [26:0] PIO2_LO_Q64     = 27'sh2D1846A;

   // cosine: 1 + K2 x^2 + K4 x^4 + K6 x^6 + K8 x^8 + K10 x^10
   localparam coef_type COS_K10 = -42'sd299467;
   localparam coef_type COS_K8  =  42'sd27267726;
   localparam coef_type COS_K6  = -42'sd1527099061;
   localparam coef_type COS_K4  =  42'sd45812984458;
   localparam coef_type COS_K2  = -42'sd549755813888;
   localparam coef_type ONE_Q40 =  42'sd1099511627776;

   // sine: x + S3 x^3 + S5 x^5 + S7 x^7 + S9 x^9
   localparam coef_type SIN_S9 =  42'sd2988606;
   localparam coef_type SIN_S7 = -42'sd218135545;
   localparam coef_type SIN_S5 =  42'sd9162592469;
   localparam coef_type SIN_S3 = -42'sd183251937678;

endpackage

// ----- rtl/smu_if.sv -----
// ----------------------------------------------------------------------------
// smu_if
// Valid/ready stream channels for angle beats and sine beats.
// ----------------------------------------------------------------------------
interface smu_angle_if;
   import smu_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle;
   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

interface smu_sine_if;
   import smu_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [SINE_W-1:0] sine;
   modport source (output valid, output sine, input ready);
   modport sink   (input valid, input sine, output ready);
endinterface

// ----- rtl/sine_minimax_unit_top.sv -----
// ----------------------------------------------------------------------------
// sine_minimax_unit_top
// Pipelined fixed-point sine: quadrant reduction plus minimax polynomials.
// ----------------------------------------------------------------------------
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+---------------------------------
//   req_bus   | in  | valid / ready    | angle, signed Q8.24 radians
//   rsp_bus   | out | valid / ready    | sine,  signed Q2.30
//
// One angle beat per cycle while the skid register is empty; an accepted
// angle passes 21 pipeline stages plus the output register before its sine
// shows on rsp_bus. Depth is set by the sine branch: five chained Q.40
// multiplies after the two-step range reduction.
// Reset (synchronous, active high) clears only valid bits and the output
// skid; datapath registers are not reset.
// A stall on rsp_bus first parks one result in the skid register, then
// freezes the whole pipeline; req_bus.ready is a plain flop output.
//
module sine_minimax_unit_top #(
   parameter int ANGLE_FRAC_BITS = 24,
   parameter int OUT_FRAC_BITS   = 30
) (
   input  logic       clock,
   input  logic       reset,
   smu_angle_if.sink  req_bus,
   smu_sine_if.source rsp_bus
);
   import smu_pkg::*;

   localparam int Q_W     = ANGLE_W - ANGLE_FRAC_BITS;   // signed quadrant count
   localparam int T_SHIFT = QF - ANGLE_FRAC_BITS;
   localparam int HI_W    = Q_W + TW;
   localparam int LO_W    = Q_W + 27;
   localparam int O_SHIFT = QF - OUT_FRAC_BITS;
   localparam int DEPTH   = 21;

   // ---------------------------------------------------------------------
   // Flow control: one global advance, valid bits shift with the data
   // ---------------------------------------------------------------------
   logic             en;
   logic [DEPTH:1]   vld_ff;
   logic             skid_vld_ff;
   logic [SINE_W-1:0] skid_sine_ff;
   logic             rsp_vld_ff;
   logic [SINE_W-1:0] rsp_sine_ff;
   logic             push;
   logic             pop;

   assign en            = !skid_vld_ff;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-1:1], req_bus.valid};
      end
   end

   // ---------------------------------------------------------------------
   // Stages 1-3: capture, times 2/pi, round to quadrant count
   // ---------------------------------------------------------------------
   logic signed [ANGLE_W-1:0] angle1_ff, angle2_ff, angle3_ff;
   logic [ANGLE_W-1:0]        mag2;
   logic [63:0]               p2_in, p2_ff;
   logic                      neg2_ff;
   logic [63:0]               qsum;
   logic [Q_W-1:0]            qmag;
   logic signed [Q_W-1:0]     q3_in, q3_ff;

   always_comb begin
      mag2  = angle1_ff[ANGLE_W-1] ? ANGLE_W'(-angle1_ff) : ANGLE_W'(angle1_ff);
      p2_in = 64'(mag2) * 64'(TWO_OVER_PI_Q32);
      qsum  = p2_ff + (64'(1) << (ANGLE_FRAC_BITS + 31));
      qmag  = qsum[ANGLE_FRAC_BITS + 32 +: Q_W];
      q3_in = neg2_ff ? $signed(Q_W'(0) - qmag) : $signed(qmag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle1_ff <= req_bus.angle;
         angle2_ff <= angle1_ff;
         neg2_ff   <= angle1_ff[ANGLE_W-1];
         p2_ff     <= p2_in;
         angle3_ff <= angle2_ff;
         q3_ff     <= q3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 4-6: Cody-Waite reduction, t = a - q*hi - round(q*lo)
   // ---------------------------------------------------------------------
   logic signed [HI_W-1:0] hi4_in, hi4_ff;
   logic signed [LO_W-1:0] lo4_in, lo4_ff;
   logic signed [63:0]     t0_4_in, t0_4_ff;
   logic signed [63:0]     t1_5_in, t1_5_ff;
   logic [LO_W-1:0]        lo_mag;
   logic [LO_W-1:0]        lo_rnd;
   logic signed [LO_W-1:0] lor5_in, lor5_ff;
   coef_type               t6_in;
   logic [1:0]             quad_ff [4:19];

   always_comb begin
      hi4_in  = HI_W'(q3_ff) * HI_W'(PIO2_HI_Q40);
      lo4_in  = LO_W'(q3_ff) * LO_W'(PIO2_LO_Q64);
      t0_4_in = 64'(angle3_ff) <<< T_SHIFT;
      t1_5_in = t0_4_ff - 64'(hi4_ff);
      lo_mag  = lo4_ff[LO_W-1] ? LO_W'(-lo4_ff) : LO_W'(lo4_ff);
      lo_rnd  = (lo_mag + (LO_W'(1) << (LO_SHIFT - 1))) >> LO_SHIFT;
      lor5_in = lo4_ff[LO_W-1] ? $signed(LO_W'(0) - lo_rnd) : $signed(lo_rnd);
      t6_in   = coef_type'(t1_5_ff - 64'(lor5_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi4_ff      <= hi4_in;
         lo4_ff      <= lo4_in;
         t0_4_ff     <= t0_4_in;
         quad_ff[4]  <= q3_ff[1:0];
         t1_5_ff     <= t1_5_in;
         lor5_ff     <= lor5_in;
         for (int i = 5; i <= 19; i++) begin
            quad_ff[i] <= quad_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stages 6-19: both polynomials run side by side, picked at stage 20
   // ---------------------------------------------------------------------
   coef_type t_ff [6:18];      // reduced angle, tapped at 6, 16 and 18
   coef_type x2_ff [9:14];
   coef_type x2_q, x4_q, x8_q;
   coef_type c10_q, c6_q, c2_q, s9_q, s5_q;
   coef_type x4_11_ff;
   coef_type ca11_ff, cb11_ff, cc11_ff, sa11_ff, sb11_ff;
   coef_type ca12_ff, cc12_ff, cc13_ff, cc14_ff, sb12_ff, sb13_ff;
   coef_type b_q, sap_q, a_q;
   coef_type b14_ff, p14_ff;
   coef_type px2_q, pt_q;
   coef_type cos_ff [15:19];
   coef_type sin19_ff;

   smu_qmul u_x2  (.clock, .en, .op_a(t_ff[6]),  .op_b(t_ff[6]),   .prod(x2_q));
   smu_qmul u_x4  (.clock, .en, .op_a(x2_q),     .op_b(x2_q),      .prod(x4_q));
   smu_qmul u_c10 (.clock, .en, .op_a(COS_K10),  .op_b(x2_q),      .prod(c10_q));
   smu_qmul u_c6  (.clock, .en, .op_a(COS_K6),   .op_b(x2_q),      .prod(c6_q));
   smu_qmul u_c2  (.clock, .en, .op_a(COS_K2),   .op_b(x2_q),      .prod(c2_q));
   smu_qmul u_s9  (.clock, .en, .op_a(SIN_S9),   .op_b(x2_q),      .prod(s9_q));
   smu_qmul u_s5  (.clock, .en, .op_a(SIN_S5),   .op_b(x2_q),      .prod(s5_q));
   smu_qmul u_x8  (.clock, .en, .op_a(x4_q),     .op_b(x4_q),      .prod(x8_q));
   smu_qmul u_b   (.clock, .en, .op_a(cb11_ff),  .op_b(x4_11_ff),  .prod(b_q));
   smu_qmul u_sa  (.clock, .en, .op_a(sa11_ff),  .op_b(x4_11_ff),  .prod(sap_q));
   smu_qmul u_a   (.clock, .en, .op_a(ca12_ff),  .op_b(x8_q),      .prod(a_q));
   smu_qmul u_px2 (.clock, .en, .op_a(p14_ff),   .op_b(x2_ff[14]), .prod(px2_q));
   smu_qmul u_pt  (.clock, .en, .op_a(px2_q),    .op_b(t_ff[16]),  .prod(pt_q));

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[6] <= t6_in;
         for (int i = 7; i <= 18; i++) begin
            t_ff[i] <= t_ff[i-1];
         end
         x2_ff[9] <= x2_q;
         for (int i = 10; i <= 14; i++) begin
            x2_ff[i] <= x2_ff[i-1];
         end
         // stage 11: inner Horner adds
         x4_11_ff <= x4_q;
         ca11_ff  <= c10_q + COS_K8;
         cb11_ff  <= c6_q + COS_K4;
         cc11_ff  <= c2_q + ONE_Q40;
         sa11_ff  <= s9_q + SIN_S7;
         sb11_ff  <= s5_q + SIN_S3;
         // alignment
         ca12_ff  <= ca11_ff;
         cc12_ff  <= cc11_ff;
         cc13_ff  <= cc12_ff;
         cc14_ff  <= cc13_ff;
         sb12_ff  <= sb11_ff;
         sb13_ff  <= sb12_ff;
         b14_ff   <= b_q;
         // stage 14: sine inner sum; stage 15: cosine result
         p14_ff     <= sap_q + sb13_ff;
         cos_ff[15] <= a_q + b14_ff + cc14_ff;
         for (int i = 16; i <= 19; i++) begin
            cos_ff[i] <= cos_ff[i-1];
         end
         // stage 19: sine result
         sin19_ff <= pt_q + t_ff[18];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 20-21: select, round to output format, clamp to 1.0, sign
   // ---------------------------------------------------------------------
   coef_type                 r_sel;
   logic [TW-1:0]            r_mag;
   logic [TW-1:0]            r_rnd;
   logic [TW-1:0]            lim;
   logic [OUT_FRAC_BITS:0]   msat20_in, msat20_ff;
   logic                     neg20_in, neg20_ff;
   logic [SINE_W-1:0]        res21_in, res21_ff;

   always_comb begin
      r_sel     = quad_ff[19][0] ? cos_ff[19] : sin19_ff;
      r_mag     = r_sel[TW-1] ? TW'(-r_sel) : TW'(r_sel);
      r_rnd     = (r_mag + (TW'(1) << (O_SHIFT - 1))) >> O_SHIFT;
      lim       = TW'(1) << OUT_FRAC_BITS;
      msat20_in = (r_rnd > lim) ? lim[OUT_FRAC_BITS:0] : r_rnd[OUT_FRAC_BITS:0];
      neg20_in  = r_sel[TW-1] ^ quad_ff[19][1];
      res21_in  = neg20_ff ? (SINE_W'(0) - SINE_W'(msat20_ff)) : SINE_W'(msat20_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         msat20_ff <= msat20_in;
         neg20_ff  <= neg20_in;
         res21_ff  <= res21_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register plus one-beat skid
   // ---------------------------------------------------------------------
   assign push = en && vld_ff[DEPTH];
   assign pop  = rsp_vld_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            rsp_sine_ff <= skid_sine_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_vld_ff || pop) begin
            rsp_sine_ff <= res21_ff;
            rsp_vld_ff  <= 1'b1;
         end else begin
            skid_sine_ff <= res21_ff;
            skid_vld_ff  <= 1'b1;
         end
      end else if (pop) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.sine  = rsp_sine_ff;

endmodule

// ----- rtl/smu_qmul.sv -----
// ----------------------------------------------------------------------------
// smu_qmul
// Two-stage Q.40 multiply, rounded half away from zero.
// ----------------------------------------------------------------------------
module smu_qmul (
   input  logic             clock,
   input  logic             en,
   input  smu_pkg::coef_type op_a,
   input  smu_pkg::coef_type op_b,
   output smu_pkg::coef_type prod
);
   import smu_pkg::*;

   localparam int LO_PW = TW + PP_LO_W;        // |a| * low slice
   localparam int HI_PW = 2*TW - PP_LO_W;      // |a| * high slice
   localparam int SUM_W = 2*TW;

   logic [TW-1:0]    mag_a;
   logic [TW-1:0]    mag_b;
   logic [LO_PW-1:0] part_lo_in, part_lo_ff;
   logic [HI_PW-1:0] part_hi_in, part_hi_ff;
   logic             neg_in, neg_ff;
   logic [SUM_W-1:0] sum;
   logic [TW-1:0]    rnd;
   coef_type         prod_in, prod_ff;

   // stage 1: magnitudes and split partial products
   always_comb begin
      mag_a      = op_a[TW-1] ? TW'(-op_a) : TW'(op_a);
      mag_b      = op_b[TW-1] ? TW'(-op_b) : TW'(op_b);
      neg_in     = op_a[TW-1] ^ op_b[TW-1];
      part_lo_in = LO_PW'(mag_a) * LO_PW'(mag_b[PP_LO_W-1:0]);
      part_hi_in = HI_PW'(mag_a) * HI_PW'(mag_b[TW-1:PP_LO_W]);
   end

   // stage 2: recombine, round at bit 40, apply sign
   always_comb begin
      sum = {part_hi_ff, PP_LO_W'(0)} + SUM_W'(part_lo_ff)
            + (SUM_W'(1) << (QF - 1));
      rnd = sum[QF +: TW];
      prod_in = neg_ff ? coef_type'(TW'(0) - rnd) : coef_type'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
         neg_ff     <= neg_in;
         prod_ff    <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/smu_checker.sv -----
// ----------------------------------------------------------------------------
// smu_checker
// Port-level checks on the sine unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smu_checker #(
   parameter int OUT_FRAC_BITS = 30
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] rsp_sine
);
   localparam logic signed [31:0] LIM = 32'sd1 <<< OUT_FRAC_BITS;

   logic [7:0] count_ff, count_in;
   logic       in_beat, out_beat;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   // beats accepted but not yet delivered
   always_comb begin
      count_in = count_ff + {7'd0, in_beat} - {7'd0, out_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `SMU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sine))
   `SMU_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, (rsp_sine <= LIM) && (rsp_sine >= -LIM))
   `SMU_ASSERT_NOW(a_no_phantom, clock, reset, out_beat, count_ff != 8'd0)
   `SMU_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready))
   `SMU_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind sine_minimax_unit_top smu_checker #(
   .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_smu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_sine  (rsp_bus.sine)
);

// ----- verif/smu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_sine_checker
// Watches the angle and sine channels, predicts each sine from its angle
// and compares every sine beat with the oldest prediction.
// ----------------------------------------------------------------------------
module smu_sine_checker #(
   parameter int ANGLE_FRAC_BITS = 24,
   parameter int OUT_FRAC_BITS   = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [smu_pkg::ANGLE_W-1:0]  req_angle,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [smu_pkg::SINE_W-1:0]   rsp_sine,
   output int                                  mismatches,
   output int                                  sines_due
);

   // Q.40 constants of the evaluator
   localparam longint unsigned TWO_PI_INV = 64'hA2F9836E;     // 2/pi, Q0.32
   localparam longint HALF_PI_HI = 64'sh1921FB54440;          // Q.40
   localparam longint HALF_PI_LO = 64'sh2D1846A;              // Q.64
   localparam longint ONE        = 64'sd1099511627776;

   localparam longint C10 = -64'sd299467;
   localparam longint C8  =  64'sd27267726;
   localparam longint C6  = -64'sd1527099061;
   localparam longint C4  =  64'sd45812984458;
   localparam longint C2  = -64'sd549755813888;

   localparam longint S9 =  64'sd2988606;
   localparam longint S7 = -64'sd218135545;
   localparam longint S5 =  64'sd9162592469;
   localparam longint S3 = -64'sd183251937678;

   typedef struct {
      logic signed [smu_pkg::ANGLE_W-1:0] angle;
      logic signed [smu_pkg::SINE_W-1:0]  sine;
   } sine_beat_type;

   sine_beat_type expected_sines[$];
   int            error_total = 0;

   function automatic longint unsigned magnitude(longint v);
      longint unsigned m;
      m = v;
      if (v < 0) m = 64'd0 - m;
      return m;
   endfunction

   // divide by 2^s, halves away from zero
   function automatic longint round_shift(longint v, int s);
      longint unsigned m;
      m = (magnitude(v) + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   // Q.40 product in two partial products, rounded half away from zero
   function automatic longint mul_q40(longint a, longint b);
      longint unsigned ma, mb, lo, acc;
      ma  = magnitude(a);
      mb  = magnitude(b);
      lo  = ma * (mb & 64'hFFFFF) + (64'd1 << 39);
      acc = ma * (mb >> 20) + (lo >> 20);
      acc = acc >> 20;
      return ((a < 0) != (b < 0)) ? -longint'(acc) : longint'(acc);
   endfunction

   function automatic longint cos_series(longint t);
      longint x2, x4, x8, hi, mid, lo;
      x2  = mul_q40(t, t);
      x4  = mul_q40(x2, x2);
      x8  = mul_q40(x4, x4);
      hi  = mul_q40(mul_q40(C10, x2) + C8, x8);
      mid = mul_q40(mul_q40(C6, x2) + C4, x4);
      lo  = mul_q40(C2, x2) + ONE;
      return hi + mid + lo;
   endfunction

   function automatic longint sin_series(longint t);
      longint x2, x4, p;
      x2 = mul_q40(t, t);
      x4 = mul_q40(x2, x2);
      p  = mul_q40(mul_q40(S9, x2) + S7, x4) + (mul_q40(S5, x2) + S3);
      return mul_q40(mul_q40(p, x2), t) + t;
   endfunction

   function automatic logic signed [smu_pkg::SINE_W-1:0] sine_of_angle(
      logic signed [smu_pkg::ANGLE_W-1:0] angle);
      longint          a, q, t, r, o, lim;
      longint unsigned prod, qm;
      logic [1:0]      quad;
      a    = angle;
      prod = magnitude(a) * TWO_PI_INV;
      qm   = (prod + (64'd1 << (ANGLE_FRAC_BITS + 31))) >> (ANGLE_FRAC_BITS + 32);
      q    = (a < 0) ? -longint'(qm) : longint'(qm);
      quad = q[1:0];
      t    = a * (longint'(1) << (40 - ANGLE_FRAC_BITS));
      t    = t - q * HALF_PI_HI;
      t    = t - round_shift(q * HALF_PI_LO, 24);
      r    = quad[0] ? cos_series(t) : sin_series(t);
      o    = round_shift(r, 40 - OUT_FRAC_BITS);
      lim  = longint'(1) << OUT_FRAC_BITS;
      if (o > lim) o = lim;
      if (o < -lim) o = -lim;
      if (quad[1]) o = -o;
      return o[smu_pkg::SINE_W-1:0];
   endfunction

   always @(posedge clock) begin
      sine_beat_type beat;
      sine_beat_type oldest;
      if (reset) begin
         expected_sines.delete();
      end else begin
         if (req_valid && req_ready) begin
            beat.angle = req_angle;
            beat.sine  = sine_of_angle(req_angle);
            expected_sines.push_back(beat);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_sines.size() == 0) begin
               $error("sine beat with none expected: actual %0d", rsp_sine);
               error_total++;
            end else begin
               oldest = expected_sines.pop_front();
               if (rsp_sine !== oldest.sine) begin
                  $error("sine (angle %0d): expected %0d, actual %0d",
                         oldest.angle, oldest.sine, rsp_sine);
                  error_total++;
               end
            end
         end
      end
      mismatches <= error_total;
      sines_due  <= expected_sines.size();
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives angle beats into the sine unit in random bursts, stalls the sine
// channel on its own pattern and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ANGLE_FRAC_BITS = 24;
   localparam int OUT_FRAC_BITS   = 30;
   localparam int RANDOM_ANGLES   = 550;
   localparam int DRAIN_CYCLES    = 40;    // quiet margin after the last expected sine
   localparam int IDLE_LIMIT      = 2000;  // cycles with no beat on either channel

   logic clock;
   logic reset;
   int   mismatches;
   int   sines_due;
   int   idle_cycles;
   int   stall_left;
   int   run_left;

   // edge and boundary angles, Q8.24
   int directed_angles[25] = '{
      0, 1, -1, 32'h7FFFFFFF, 32'h80000000,
      16777216, -16777216,                 // +-1.0 rad
      26353589, -26353589,                 // +-pi/2, cosine near one: saturation
      52707179, -52707179,                 // +-pi
      79060768, -79060768,                 // +-3pi/2
      105414357,                           // 2pi
      13176794, 13176795, -13176794, -13176795,  // quadrant rounding at pi/4
      39530384, 39530383, -39530384,             // and at 3pi/4
      8, 32'h40000000, 32'hC0000000, 32'h00FFFFFF
   };

   smu_angle_if angle_ch ();
   smu_sine_if  sine_ch ();

   sine_minimax_unit_top #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS   (OUT_FRAC_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (angle_ch),
      .rsp_bus (sine_ch)
   );

   smu_sine_checker #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS   (OUT_FRAC_BITS)
   ) sine_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (angle_ch.valid),
      .req_ready  (angle_ch.ready),
      .req_angle  (angle_ch.angle),
      .rsp_valid  (sine_ch.valid),
      .rsp_ready  (sine_ch.ready),
      .rsp_sine   (sine_ch.sine),
      .mismatches (mismatches),
      .sines_due  (sines_due)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // sink side: a run of ready cycles, then a stall of random length
   // (often none, which gives long stretches without back-pressure)
   always @(posedge clock) begin
      if (reset) begin
         sine_ch.ready <= 1'b0;
         stall_left    <= 0;
         run_left      <= 0;
      end else if (stall_left > 0) begin
         sine_ch.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (run_left > 0) begin
         sine_ch.ready <= 1'b1;
         run_left      <= run_left - 1;
      end else begin
         sine_ch.ready <= 1'b1;
         run_left      <= $urandom_range(1, 40);
         stall_left    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
   end

   // watchdog: count cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((angle_ch.valid && angle_ch.ready) || (sine_ch.valid && sine_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // one random angle: full 32-bit patterns, angles within about one turn
   // of zero, and points close to multiples of pi/4 (odd ones flip the quadrant)
   function automatic logic signed [31:0] random_angle();
      int     pick;
      longint k;
      longint base;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         return $urandom;
      end else if (pick < 8) begin
         return int'($urandom_range(0, 220000000)) - 110000000;
      end else begin
         k    = int'($urandom_range(0, 320)) - 160;
         base = (k * 64'sd3373259426) >>> 8;    // k * pi/4 in Q8.24
         return 32'(base + (int'($urandom_range(0, 128)) - 64));
      end
   endfunction

   // hold one beat on the angle channel until it is taken; valid stays up
   task automatic send_angle(input logic signed [31:0] value);
      angle_ch.valid <= 1'b1;
      angle_ch.angle <= value;
      do @(posedge clock); while (!angle_ch.ready);
   endtask

   task automatic pause_sender();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
         angle_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int sent;
      int burst;
      angle_ch.valid = 1'b0;
      angle_ch.angle = '0;
      reset          = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed angles, split into a few bursts
      foreach (directed_angles[i]) begin
         send_angle(directed_angles[i]);
         if (i % 7 == 6) pause_sender();
      end
      pause_sender();

      sent = 0;
      while (sent < RANDOM_ANGLES) begin
         burst = $urandom_range(1, 24);
         for (int n = 0; n < burst && sent < RANDOM_ANGLES; n++) begin
            send_angle(random_angle());
            sent++;
         end
         pause_sender();
      end
      angle_ch.valid <= 1'b0;
      @(posedge clock);

      // drain: every predicted sine must come back, then a quiet margin
      while (sines_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && sines_due == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/smu_pkg.sv
rtl/smu_if.sv
rtl/smu_qmul.sv
rtl/sine_minimax_unit_top.sv
rtl/smu_checker.sv
verif/smu_checker.sv
verif/tb_top.sv
